// ===== rtl/core/deq_pkg.sv =====
// shared types, codes and constants for the double-ended queue
package deq_pkg;

    localparam int DATA_W    = 32;
    localparam int DEPTH_DEF = 32;
    localparam int COUNT_W   = 6;

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_WALK_FWD   = 3'd4;
    localparam logic [2:0] OP_WALK_BWD   = 3'd5;
    localparam logic [2:0] OP_CLEAR      = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_PUSH_F,
        CMD_PUSH_B,
        CMD_POP_F,
        CMD_POP_B,
        CMD_ROT_L,
        CMD_ROT_R,
        CMD_CLEAR
    } t_cell_cmd;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              valid;
    } t_link;

endpackage

// ===== rtl/core/double_ended_queue.sv =====
// top level: double-ended queue built as a chain of shifting cells
// push, pop and clear: one word per cycle while the output is not stalled, result registered
// at acceptance; walk of n elements: acceptance enters S_WALK, then one result per cycle unless stalled;
//   input stalled during the walk, the chain rotates one cell per result, back in order
// a stalled result holds the next word back; pop data comes straight from the end cells
// synchronous active-low reset empties the queue at once (cell valid bits cleared)
module double_ended_queue #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [2:0]                   i_opcode,
    input  logic signed [deq_pkg::DATA_W-1:0] i_value,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [deq_pkg::DATA_W-1:0] o_data,
    output logic [deq_pkg::COUNT_W-1:0]  o_item_count,
    output logic [1:0]                   o_status,
    output logic                         o_last
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_CNT  = CW'(1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WALK = 2'b10
    } t_state;

    t_state                     r_state, n_state;
    logic [CW-1:0]              r_count, n_count;
    logic [CW-1:0]              r_remain, n_remain;
    logic                       r_dir_bwd, n_dir_bwd;
    logic                       r_out_valid, n_out_valid;
    logic                       load_out;
    logic [deq_pkg::DATA_W-1:0] n_out_data, r_out_data;
    logic [1:0]                 n_out_status, r_out_status;
    logic                       n_out_last, r_out_last;
    logic [deq_pkg::COUNT_W-1:0] r_out_count;
    logic [CW+deq_pkg::COUNT_W-1:0] cnt_ext;

    deq_pkg::t_cell_cmd         cmd;
    deq_pkg::t_link             links [DEPTH];
    deq_pkg::t_link             left_in [DEPTH];
    deq_pkg::t_link             right_in [DEPTH];
    logic [DEPTH-1:0]           is_last;
    logic [deq_pkg::DATA_W-1:0] front, back;

    logic out_free, accept;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && out_free);
    assign accept     = i_in_valid && !o_in_stall;

    assign front = links[0].data;

    always_comb begin
        back = '0;
        for (int k = 0; k < DEPTH; k++) begin
            back = back | (links[k].data & {deq_pkg::DATA_W{is_last[k]}});
        end
    end

    // chain boundaries and neighbor wiring
    always_comb begin
        left_in[0].data  = (cmd == deq_pkg::CMD_ROT_R) ? back : i_value;
        left_in[0].valid = 1'b1;
        for (int k = 1; k < DEPTH; k++) begin
            left_in[k] = links[k-1];
        end
        for (int k = 0; k < DEPTH - 1; k++) begin
            right_in[k] = links[k+1];
        end
        right_in[DEPTH-1] = '0;
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        deq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd),
            .i_value (i_value),
            .i_front (front),
            .i_left  (left_in[g]),
            .i_right (right_in[g]),
            .o_link  (links[g]),
            .o_last  (is_last[g])
        );
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_remain     = r_remain;
        n_dir_bwd    = r_dir_bwd;
        n_out_valid  = r_out_valid;
        load_out     = 1'b0;
        n_out_data   = '0;
        n_out_status = deq_pkg::ST_OK;
        n_out_last   = 1'b1;
        cmd          = deq_pkg::CMD_HOLD;
        if (out_free) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    unique case (i_opcode) inside
                        deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
                            if (r_count == FULL_CNT) begin
                                n_out_status = deq_pkg::ST_FULL;
                            end else begin
                                cmd     = (i_opcode == deq_pkg::OP_PUSH_FRONT) ?
                                          deq_pkg::CMD_PUSH_F : deq_pkg::CMD_PUSH_B;
                                n_count = r_count + ONE_CNT;
                            end
                        end
                        deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
                            if (r_count == '0) begin
                                n_out_status = deq_pkg::ST_EMPTY;
                            end else if (i_opcode == deq_pkg::OP_POP_FRONT) begin
                                n_out_data = front;
                                cmd        = deq_pkg::CMD_POP_F;
                                n_count    = r_count - ONE_CNT;
                            end else begin
                                n_out_data = back;
                                cmd        = deq_pkg::CMD_POP_B;
                                n_count    = r_count - ONE_CNT;
                            end
                        end
                        deq_pkg::OP_WALK_FWD, deq_pkg::OP_WALK_BWD: begin
                            if (r_count == '0) begin
                                n_out_status = deq_pkg::ST_EMPTY;
                            end else begin
                                load_out    = 1'b0;
                                n_out_valid = 1'b0;
                                n_state     = S_WALK;
                                n_remain    = r_count;
                                n_dir_bwd   = (i_opcode == deq_pkg::OP_WALK_BWD);
                            end
                        end
                        deq_pkg::OP_CLEAR: begin
                            cmd     = deq_pkg::CMD_CLEAR;
                            n_count = '0;
                        end
                        default: begin
                            cmd = deq_pkg::CMD_HOLD;
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (out_free) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_data  = r_dir_bwd ? back : front;
                    cmd         = r_dir_bwd ? deq_pkg::CMD_ROT_R : deq_pkg::CMD_ROT_L;
                    n_out_last  = (r_remain == ONE_CNT);
                    n_remain    = r_remain - ONE_CNT;
                    if (r_remain == ONE_CNT) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign cnt_ext = {{deq_pkg::COUNT_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_remain    <= '0;
            r_dir_bwd   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_remain    <= n_remain;
            r_dir_bwd   <= n_dir_bwd;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data   <= n_out_data;
            r_out_status <= n_out_status;
            r_out_last   <= n_out_last;
            r_out_count  <= cnt_ext[deq_pkg::COUNT_W-1:0];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_data       = r_out_data;
    assign o_item_count = r_out_count;
    assign o_status     = r_out_status;
    assign o_last       = r_out_last;

endmodule

// ===== rtl/core/deq_cell.sv =====
// one storage cell of the queue chain, position k from the front
module deq_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  deq_pkg::t_cell_cmd        i_cmd,
    input  logic [deq_pkg::DATA_W-1:0] i_value,
    input  logic [deq_pkg::DATA_W-1:0] i_front,
    input  deq_pkg::t_link            i_left,
    input  deq_pkg::t_link            i_right,
    output deq_pkg::t_link            o_link,
    output logic                      o_last
);

    logic [deq_pkg::DATA_W-1:0] r_data, n_data;
    logic                       r_valid, n_valid;

    assign o_link.data  = r_data;
    assign o_link.valid = r_valid;
    assign o_last       = r_valid && !i_right.valid;

    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        unique case (i_cmd)
            deq_pkg::CMD_PUSH_F: begin
                n_data  = i_left.data;
                n_valid = i_left.valid;
            end
            deq_pkg::CMD_PUSH_B: begin
                if (!r_valid && i_left.valid) begin
                    n_data  = i_value;
                    n_valid = 1'b1;
                end
            end
            deq_pkg::CMD_POP_F: begin
                n_data  = i_right.data;
                n_valid = i_right.valid;
            end
            deq_pkg::CMD_POP_B: begin
                if (o_last) begin
                    n_valid = 1'b0;
                end
            end
            deq_pkg::CMD_ROT_L: begin
                if (i_right.valid) begin
                    n_data = i_right.data;
                end else if (r_valid) begin
                    n_data = i_front;
                end
            end
            deq_pkg::CMD_ROT_R: begin
                n_data = i_left.data;
            end
            deq_pkg::CMD_CLEAR: begin
                n_valid = 1'b0;
            end
            default: begin
                n_data  = r_data;
                n_valid = r_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

// ===== sim/tb_double_ended_queue.sv =====
// self-checking testbench for the double_ended_queue block
`timescale 1ns / 100ps

module tb_double_ended_queue;

    localparam int         DEPTH      = deq_pkg::DEPTH_DEF;
    localparam int         DATA_W     = deq_pkg::DATA_W;
    localparam int         COUNT_W    = deq_pkg::COUNT_W;
    localparam logic [2:0] OP_UNUSED  = 3'd7;
    localparam int         HOLD_LEN   = 300;
    localparam int         DRAIN_MAX  = 50000;

    typedef struct {
        logic signed [DATA_W-1:0] data;
        logic [COUNT_W-1:0]       count;
        logic [1:0]               status;
        logic                     last;
    } t_deque_result;

    logic                     i_clk        = 1'b0;
    logic                     i_rst_n      = 1'b0;
    logic                     i_in_valid   = 1'b0;
    logic [2:0]               i_opcode     = '0;
    logic signed [DATA_W-1:0] i_value      = '0;
    logic                     i_out_stall  = 1'b0;
    logic                     o_in_stall;
    logic                     o_out_valid;
    logic signed [DATA_W-1:0] o_data;
    logic [COUNT_W-1:0]       o_item_count;
    logic [1:0]               o_status;
    logic                     o_last;

    logic signed [DATA_W-1:0] shadow_store [DEPTH];
    int                       shadow_head  = 0;
    int                       shadow_count = 0;
    t_deque_result            pending_words [$];

    int mismatch_count = 0;
    bit idle_en        = 1'b1;
    bit hold_req       = 1'b0;
    int hold_left      = 0;

    double_ended_queue #(.DEPTH(DEPTH)) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_opcode     (i_opcode),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_data       (o_data),
        .o_item_count (o_item_count),
        .o_status     (o_status),
        .o_last       (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("double_ended_queue regression: fail");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic queue_word(input logic signed [DATA_W-1:0] data, input logic [1:0] status,
                              input logic last);
        t_deque_result w;
        w.data   = data;
        w.count  = shadow_count[COUNT_W-1:0];
        w.status = status;
        w.last   = last;
        pending_words.push_back(w);
    endtask

    function automatic int shadow_slot(input int offset);
        return (shadow_head + offset) % DEPTH;
    endfunction

    task automatic deque_apply(input logic [2:0] op, input logic signed [DATA_W-1:0] val);
        logic signed [DATA_W-1:0] popped;
        int                       idx;
        case (op) inside
            deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
                if (shadow_count >= DEPTH) begin
                    queue_word('0, deq_pkg::ST_FULL, 1'b1);
                end else begin
                    if (op == deq_pkg::OP_PUSH_FRONT) begin
                        shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                        shadow_store[shadow_head] = val;
                    end else begin
                        shadow_store[shadow_slot(shadow_count)] = val;
                    end
                    shadow_count++;
                    queue_word('0, deq_pkg::ST_OK, 1'b1);
                end
            end
            deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
                if (shadow_count == 0) begin
                    queue_word('0, deq_pkg::ST_EMPTY, 1'b1);
                end else begin
                    if (op == deq_pkg::OP_POP_FRONT) begin
                        popped = shadow_store[shadow_head];
                        shadow_head = shadow_slot(1);
                    end else begin
                        popped = shadow_store[shadow_slot(shadow_count - 1)];
                    end
                    shadow_count--;
                    queue_word(popped, deq_pkg::ST_OK, 1'b1);
                end
            end
            deq_pkg::OP_WALK_FWD, deq_pkg::OP_WALK_BWD: begin
                if (shadow_count == 0) begin
                    queue_word('0, deq_pkg::ST_EMPTY, 1'b1);
                end else begin
                    for (int i = 0; i < shadow_count; i++) begin
                        idx = (op == deq_pkg::OP_WALK_FWD) ? shadow_slot(i)
                                                           : shadow_slot(shadow_count - 1 - i);
                        queue_word(shadow_store[idx], deq_pkg::ST_OK, (i + 1 == shadow_count));
                    end
                end
            end
            deq_pkg::OP_CLEAR: begin
                shadow_head  = 0;
                shadow_count = 0;
                queue_word('0, deq_pkg::ST_OK, 1'b1);
            end
            default: begin
                queue_word('0, deq_pkg::ST_OK, 1'b1);
            end
        endcase
    endtask

    task automatic send_word(input logic [2:0] op, input logic signed [DATA_W-1:0] val);
        int gap;
        gap = 0;
        if (idle_en && $urandom_range(99) < 19) gap = $urandom_range(2, 1);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_value    <= val;
        do @(posedge i_clk); while (o_in_stall);
        deque_apply(op, val);
    endtask

    task automatic wait_drained();
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (pending_words.size() != 0 && waited < DRAIN_MAX) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_words.size() != 0) begin
            report_mismatch($sformatf("%0d expected words never arrived",
                                      pending_words.size()));
            pending_words.delete();
        end
    endtask

    function automatic logic [2:0] pick_op(input bit grow);
        int r;
        r = $urandom_range(99);
        if (r < 5)  return deq_pkg::OP_WALK_FWD;
        if (r < 10) return deq_pkg::OP_WALK_BWD;
        if (r < 13) return deq_pkg::OP_CLEAR;
        if (r < 16) return OP_UNUSED;
        if (grow ? (r < 76) : (r < 36))
            return (r % 2) ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK;
        return (r % 2) ? deq_pkg::OP_POP_FRONT : deq_pkg::OP_POP_BACK;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_deque_result w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word data=%0d count=%0d",
                                          o_data, o_item_count));
            end else begin
                w = pending_words.pop_front();
                if (o_data !== w.data)
                    report_mismatch($sformatf("data %0d, want %0d", o_data, w.data));
                if (o_item_count !== w.count)
                    report_mismatch($sformatf("count %0d, want %0d", o_item_count, w.count));
                if (o_status !== w.status)
                    report_mismatch($sformatf("status %0d, want %0d", o_status, w.status));
                if (o_last !== w.last)
                    report_mismatch($sformatf("last %0b, want %0b", o_last, w.last));
            end
        end
    end

    // receiver stall
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_LEN;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else if (idle_en) begin
            i_out_stall <= ($urandom_range(99) < 19);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic test_directed();
        send_word(deq_pkg::OP_POP_FRONT, 32'sd5);
        send_word(deq_pkg::OP_POP_BACK, -32'sd5);
        send_word(deq_pkg::OP_WALK_FWD, '0);
        send_word(deq_pkg::OP_WALK_BWD, '1);
        send_word(deq_pkg::OP_PUSH_FRONT, 32'sh7fffffff);
        send_word(deq_pkg::OP_PUSH_BACK, 32'sh80000000);
        send_word(deq_pkg::OP_PUSH_FRONT, -32'sd1);
        send_word(deq_pkg::OP_PUSH_BACK, 32'sd0);
        send_word(deq_pkg::OP_WALK_FWD, '0);
        send_word(deq_pkg::OP_WALK_BWD, '0);
        send_word(OP_UNUSED, 32'sh5a5a5a5a);
        send_word(deq_pkg::OP_POP_FRONT, '0);
        send_word(deq_pkg::OP_POP_BACK, '0);
        send_word(deq_pkg::OP_CLEAR, 32'sh12345678);
        send_word(deq_pkg::OP_WALK_FWD, '0);
        send_word(deq_pkg::OP_PUSH_BACK, 32'sh0000ffff);
        send_word(deq_pkg::OP_POP_BACK, '0);
    endtask

    task automatic test_full_queue();
        send_word(deq_pkg::OP_CLEAR, '0);
        for (int i = 0; i < DEPTH; i++)
            send_word(($urandom_range(1) != 0) ? deq_pkg::OP_PUSH_FRONT
                                               : deq_pkg::OP_PUSH_BACK, $urandom);
        send_word(deq_pkg::OP_PUSH_FRONT, $urandom);
        send_word(deq_pkg::OP_PUSH_BACK, $urandom);
        send_word(deq_pkg::OP_WALK_FWD, '0);
        send_word(deq_pkg::OP_WALK_BWD, '0);
        for (int i = 0; i < DEPTH / 2; i++) begin
            send_word(deq_pkg::OP_POP_FRONT, '0);
            send_word(deq_pkg::OP_POP_BACK, '0);
        end
        send_word(deq_pkg::OP_POP_BACK, '0);
    endtask

    task automatic test_random_mix();
        for (int blk = 0; blk < 4; blk++)
            for (int i = 0; i < 18; i++)
                send_word(pick_op(blk % 2 == 0), $urandom);
    endtask

    task automatic test_output_hold();
        hold_req = 1'b1;
        for (int i = 0; i < 30; i++)
            send_word((i % 6 == 5) ? deq_pkg::OP_WALK_FWD : deq_pkg::OP_PUSH_BACK, $urandom);
        wait_drained();
    endtask

    task automatic test_no_idle();
        idle_en = 1'b0;
        for (int i = 0; i < 40; i++)
            send_word(pick_op(i < 20), $urandom);
        idle_en = 1'b1;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_queue();
        test_random_mix();
        test_output_hold();
        test_no_idle();
        wait_drained();
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("double_ended_queue regression: pass");
        end else begin
            $display("double_ended_queue regression: fail");
        end
        $finish;
    end

endmodule
